// File: hdl/stgc_pkg.sv
// Shared types and constants of the STAR token grammar checker.
// No dependencies; compile first.
package stgc_pkg;

    typedef enum logic [3:0] {
        TK_END       = 4'd0,
        TK_LEXERROR  = 4'd1,
        TK_COMMENT   = 4'd2,
        TK_DATASTART = 4'd3,
        TK_SAVESTART = 4'd4,
        TK_SAVEEND   = 4'd5,
        TK_LOOPSTART = 4'd6,
        TK_STOP      = 4'd7,
        TK_TAG       = 4'd8,
        TK_VALUE     = 4'd9
    } token_kind_t;

    typedef enum logic [4:0] {
        EV_COMMENT       = 5'd0,
        EV_STARTDATA     = 5'd1,
        EV_ENDDATA       = 5'd2,
        EV_STARTSAVE     = 5'd3,
        EV_ENDSAVE       = 5'd4,
        EV_STARTLOOP     = 5'd5,
        EV_ENDLOOP       = 5'd6,
        EV_TAG           = 5'd7,
        EV_VALUE         = 5'd8,
        EV_FATAL         = 5'd9,
        EV_INVALID       = 5'd10,
        EV_VALUEEXPECTED = 5'd11,
        EV_VALUENOTEXP   = 5'd12,
        EV_NOTAGS        = 5'd13,
        EV_NOVALUES      = 5'd14,
        EV_NOSAVECLOSE   = 5'd15,
        EV_NOSTOPCLOSE   = 5'd16,
        EV_KEYWORDWARN   = 5'd17,
        EV_COUNTWARN     = 5'd18
    } event_t;

    typedef enum logic [1:0] {
        LV_FILE = 2'd0,
        LV_DATA = 2'd1,
        LV_SAVE = 2'd2,
        LV_LOOP = 2'd3
    } level_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DIV    = 2'd1,
        S_DECODE = 2'd2,
        S_EMIT   = 2'd3
    } state_t;

    localparam int MAX_EV = 3;

    localparam logic REG_ERROR_HALTS   = 1'b0;
    localparam logic REG_WARNING_HALTS = 1'b1;

endpackage

// File: hdl/stgc_token_if.sv
// Token channel: valid/ready handshake with one lexer token per beat.
// Depends on nothing; instantiated by the checker's environment.
interface stgc_token_if #(
    parameter int LINE_BITS = 24
);
    logic                 valid;
    logic                 ready;
    logic [3:0]           token_kind;
    logic [LINE_BITS-1:0] line_number;
    logic [2:0]           value_kind;
    logic                 keyword_seen;

    modport source (output valid, token_kind, line_number, value_kind, keyword_seen,
                    input ready);
    modport sink   (input valid, token_kind, line_number, value_kind, keyword_seen,
                    output ready);
endinterface

// File: hdl/stgc_event_if.sv
// Event channel: valid/ready handshake with one grammar event per beat.
// Depends on nothing; instantiated by the checker's environment.
interface stgc_event_if #(
    parameter int LINE_BITS = 24
);
    logic                 valid;
    logic                 ready;
    logic [4:0]           event_code;
    logic [LINE_BITS-1:0] event_line;
    logic [2:0]           event_value_kind;
    logic [1:0]           nesting_level;
    logic                 last_of_run;
    logic                 halted;

    modport source (output valid, event_code, event_line, event_value_kind,
                    nesting_level, last_of_run, halted, input ready);
    modport sink   (input valid, event_code, event_line, event_value_kind,
                    nesting_level, last_of_run, halted, output ready);
endinterface

// File: hdl/star_token_grammar_checker.sv
// STAR token grammar checker: nesting, tag/value pairing and loop row checks.
// Depends on stgc_pkg, stgc_token_if and stgc_event_if.
//
// Usage:
//   tokens  - sink channel, one lexer token per beat (valid/ready).
//   events  - source channel, zero to three events per token; the last beat
//             of a token carries last_of_run, and halted once parsing stops.
//   cfg_*   - write port: index 0 error_halts, index 1 warning_halts.
// Timing: one token at a time. A token is latched, then decoded, then its
//   events leave one per cycle while events.ready is high. A loop stop token
//   with tags present also runs the restoring remainder unit, one bit per
//   cycle, between latching and decoding. tokens.ready is high only while the
//   sequencer is idle.
// Stall: a stalled event beat holds its payload; the sequencer waits.
// Reset: file level, not halted, error_halts 1, warning_halts 0. After a
//   halt, tokens are still taken but produce no events until reset.
module star_token_grammar_checker #(
    parameter int COUNT_BITS = 16,
    parameter int LINE_BITS  = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    stgc_token_if.sink           tokens,
    stgc_event_if.source         events,
    input  logic                 cfg_write_en,
    input  logic                 cfg_index,
    input  logic                 cfg_data
);
    import stgc_pkg::*;

    localparam int CNT_W = $clog2(COUNT_BITS);
    localparam int Q_W   = $clog2(MAX_EV);

    state_t                state_reg, state_next;
    level_t                level_reg, level_next;
    logic                  stopped_reg, stopped_next;
    logic                  awaiting_reg, awaiting_next;
    logic                  reading_tags_reg, reading_tags_next;
    logic [COUNT_BITS-1:0] tag_count_reg, tag_count_next;
    logic [COUNT_BITS-1:0] value_count_reg, value_count_next;
    logic [COUNT_BITS-1:0] row_col_reg, row_col_next;
    logic                  prev_valid_reg, prev_valid_next;
    logic [LINE_BITS-1:0]  prev_line_reg, prev_line_next;
    logic                  first_valid_reg, first_valid_next;
    logic [LINE_BITS-1:0]  first_line_reg, first_line_next;
    logic                  error_halts_reg;
    logic                  warning_halts_reg;

    logic [3:0]            tok_kind_reg;
    logic [LINE_BITS-1:0]  tok_line_reg;
    logic [2:0]            tok_vk_reg;
    logic                  tok_kw_reg;
    level_t                tok_level_reg;
    logic [LINE_BITS-1:0]  count_line_reg, count_line_next;

    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0]      div_cnt_reg, div_cnt_next;
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;

    event_t                q_code_reg [MAX_EV];
    event_t                q_code_next [MAX_EV];
    logic [Q_W-1:0]        q_cnt_reg, q_cnt_next;
    logic [Q_W-1:0]        q_ptr_reg, q_ptr_next;

    logic                  tok_accept;
    logic                  needs_div;
    logic                  last_beat;

    assign tokens.ready = (state_reg == S_IDLE);
    assign tok_accept   = tokens.valid && tokens.ready;
    assign needs_div    = (tokens.token_kind == TK_STOP) && (level_reg == LV_LOOP)
                          && !stopped_reg && (tag_count_reg != '0);

    assign trial = {rem_reg, dvd_reg[COUNT_BITS-1]};
    assign diff  = trial - {1'b0, tag_count_reg};

    assign last_beat               = (q_ptr_reg == q_cnt_reg - 1'b1);
    assign events.valid            = (state_reg == S_EMIT);
    assign events.event_code       = q_code_reg[q_ptr_reg];
    assign events.event_line       = (q_code_reg[q_ptr_reg] == EV_COUNTWARN)
                                     ? count_line_reg : tok_line_reg;
    assign events.event_value_kind = (q_code_reg[q_ptr_reg] == EV_VALUE) ? tok_vk_reg : 3'd0;
    assign events.nesting_level    = tok_level_reg;
    assign events.last_of_run      = last_beat;
    assign events.halted           = last_beat && stopped_reg;

    always_comb
    begin
        logic [Q_W-1:0]        n;
        logic                  stop_v;
        logic                  rc_v;
        logic [COUNT_BITS-1:0] rcol_inc;

        state_next        = state_reg;
        level_next        = level_reg;
        stopped_next      = stopped_reg;
        awaiting_next     = awaiting_reg;
        reading_tags_next = reading_tags_reg;
        tag_count_next    = tag_count_reg;
        value_count_next  = value_count_reg;
        row_col_next      = row_col_reg;
        prev_valid_next   = prev_valid_reg;
        prev_line_next    = prev_line_reg;
        first_valid_next  = first_valid_reg;
        first_line_next   = first_line_reg;
        count_line_next   = count_line_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        div_cnt_next      = div_cnt_reg;
        q_code_next       = q_code_reg;
        q_cnt_next        = q_cnt_reg;
        q_ptr_next        = q_ptr_reg;
        n                 = '0;
        stop_v            = stopped_reg;
        rc_v              = 1'b0;
        rcol_inc          = (&row_col_reg) ? row_col_reg : row_col_reg + 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (tok_accept)
                begin
                    rem_next     = '0;
                    dvd_next     = value_count_reg;
                    div_cnt_next = CNT_W'(COUNT_BITS - 1);
                    state_next   = needs_div ? S_DIV : S_DECODE;
                end
            end
            S_DIV:
            begin
                rem_next     = diff[COUNT_BITS] ? trial[COUNT_BITS-1:0] : diff[COUNT_BITS-1:0];
                dvd_next     = {dvd_reg[COUNT_BITS-2:0], 1'b0};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stopped_reg)
                begin
                    case (token_kind_t'(tok_kind_reg))
                        TK_END:
                        begin
                            if (level_reg inside {LV_FILE, LV_DATA})
                            begin
                                q_code_next[n] = EV_ENDDATA;
                            end
                            else
                            begin
                                q_code_next[n] = (level_reg == LV_SAVE) ? EV_NOSAVECLOSE
                                                                        : EV_NOSTOPCLOSE;
                            end
                            n      = n + 1'b1;
                            stop_v = 1'b1;
                        end
                        TK_LEXERROR:
                        begin
                            q_code_next[n] = EV_FATAL;
                            n      = n + 1'b1;
                            stop_v = 1'b1;
                        end
                        TK_COMMENT:
                        begin
                            q_code_next[n] = EV_COMMENT;
                            n = n + 1'b1;
                        end
                        default:
                        begin
                            case (level_reg)
                                LV_FILE:
                                begin
                                    if (tok_kind_reg == TK_DATASTART)
                                    begin
                                        q_code_next[n] = EV_STARTDATA;
                                        level_next = LV_DATA;
                                    end
                                    else
                                    begin
                                        q_code_next[n] = EV_INVALID;
                                        stop_v = error_halts_reg;
                                    end
                                    n = n + 1'b1;
                                end
                                LV_DATA:
                                begin
                                    if (tok_kind_reg == TK_SAVESTART)
                                    begin
                                        q_code_next[n] = EV_STARTSAVE;
                                        level_next    = LV_SAVE;
                                        awaiting_next = 1'b0;
                                    end
                                    else
                                    begin
                                        q_code_next[n] = EV_INVALID;
                                        stop_v = error_halts_reg;
                                    end
                                    n = n + 1'b1;
                                end
                                LV_SAVE:
                                begin
                                    case (token_kind_t'(tok_kind_reg))
                                        TK_SAVEEND, TK_LOOPSTART, TK_TAG:
                                        begin
                                            if (awaiting_reg)
                                            begin
                                                q_code_next[n] = EV_VALUEEXPECTED;
                                                n      = n + 1'b1;
                                                stop_v = error_halts_reg;
                                            end
                                            if (!stop_v)
                                            begin
                                                if (tok_kind_reg == TK_SAVEEND)
                                                begin
                                                    q_code_next[n] = EV_ENDSAVE;
                                                    level_next = LV_DATA;
                                                end
                                                else if (tok_kind_reg == TK_LOOPSTART)
                                                begin
                                                    q_code_next[n]    = EV_STARTLOOP;
                                                    level_next        = LV_LOOP;
                                                    reading_tags_next = 1'b1;
                                                    tag_count_next    = '0;
                                                    value_count_next  = '0;
                                                    row_col_next      = '0;
                                                    prev_valid_next   = 1'b0;
                                                    first_valid_next  = 1'b0;
                                                end
                                                else
                                                begin
                                                    q_code_next[n] = EV_TAG;
                                                    awaiting_next  = 1'b1;
                                                end
                                                n = n + 1'b1;
                                            end
                                        end
                                        TK_VALUE:
                                        begin
                                            if (!awaiting_reg)
                                            begin
                                                q_code_next[n] = EV_VALUENOTEXP;
                                                n      = n + 1'b1;
                                                stop_v = error_halts_reg;
                                            end
                                            if (!stop_v)
                                            begin
                                                awaiting_next = 1'b0;
                                                if (tok_kw_reg)
                                                begin
                                                    q_code_next[n] = EV_KEYWORDWARN;
                                                    n      = n + 1'b1;
                                                    stop_v = warning_halts_reg;
                                                end
                                                if (!stop_v)
                                                begin
                                                    q_code_next[n] = EV_VALUE;
                                                    n = n + 1'b1;
                                                end
                                            end
                                        end
                                        default:
                                        begin
                                            q_code_next[n] = EV_INVALID;
                                            n      = n + 1'b1;
                                            stop_v = error_halts_reg;
                                        end
                                    endcase
                                end
                                default:
                                begin
                                    case (token_kind_t'(tok_kind_reg))
                                        TK_STOP:
                                        begin
                                            if (tag_count_reg == '0)
                                            begin
                                                q_code_next[n] = EV_NOTAGS;
                                                n      = n + 1'b1;
                                                stop_v = error_halts_reg;
                                            end
                                            if (!stop_v && value_count_reg == '0)
                                            begin
                                                q_code_next[n] = EV_NOVALUES;
                                                n      = n + 1'b1;
                                                stop_v = error_halts_reg;
                                            end
                                            if (!stop_v)
                                            begin
                                                if (tag_count_reg != '0 && rem_reg != '0)
                                                begin
                                                    q_code_next[n]  = EV_COUNTWARN;
                                                    count_line_next = first_valid_reg
                                                                      ? first_line_reg
                                                                      : tok_line_reg;
                                                    n    = n + 1'b1;
                                                    rc_v = warning_halts_reg;
                                                end
                                                q_code_next[n] = EV_ENDLOOP;
                                                n = n + 1'b1;
                                                if (rc_v)
                                                begin
                                                    stop_v = 1'b1;
                                                end
                                                else
                                                begin
                                                    level_next = LV_SAVE;
                                                end
                                            end
                                        end
                                        TK_TAG:
                                        begin
                                            if (!reading_tags_reg)
                                            begin
                                                q_code_next[n] = EV_VALUEEXPECTED;
                                                n      = n + 1'b1;
                                                stop_v = error_halts_reg;
                                            end
                                            if (!stop_v)
                                            begin
                                                q_code_next[n] = EV_TAG;
                                                n = n + 1'b1;
                                                tag_count_next = (&tag_count_reg)
                                                                 ? tag_count_reg
                                                                 : tag_count_reg + 1'b1;
                                            end
                                        end
                                        TK_VALUE:
                                        begin
                                            if (tag_count_reg == '0)
                                            begin
                                                q_code_next[n] = EV_NOTAGS;
                                                n      = n + 1'b1;
                                                stop_v = error_halts_reg;
                                            end
                                            if (!stop_v)
                                            begin
                                                reading_tags_next = 1'b0;
                                                value_count_next  = (&value_count_reg)
                                                                    ? value_count_reg
                                                                    : value_count_reg + 1'b1;
                                                row_col_next      = rcol_inc;
                                                if (rcol_inc == tag_count_reg)
                                                begin
                                                    if (!prev_valid_reg
                                                        || prev_line_reg < tok_line_reg)
                                                    begin
                                                        if (!first_valid_reg)
                                                        begin
                                                            first_valid_next = 1'b1;
                                                            first_line_next  = tok_line_reg;
                                                        end
                                                        prev_valid_next = 1'b1;
                                                        prev_line_next  = tok_line_reg;
                                                    end
                                                    row_col_next = '0;
                                                end
                                                if (tok_kw_reg)
                                                begin
                                                    q_code_next[n] = EV_KEYWORDWARN;
                                                    n      = n + 1'b1;
                                                    stop_v = warning_halts_reg;
                                                end
                                                if (!stop_v)
                                                begin
                                                    q_code_next[n] = EV_VALUE;
                                                    n = n + 1'b1;
                                                end
                                            end
                                        end
                                        default:
                                        begin
                                            q_code_next[n] = EV_INVALID;
                                            n      = n + 1'b1;
                                            stop_v = error_halts_reg;
                                        end
                                    endcase
                                end
                            endcase
                        end
                    endcase
                end
                stopped_next = stop_v;
                q_cnt_next   = n;
                q_ptr_next   = '0;
                state_next   = (n != '0) ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (events.ready)
                begin
                    if (last_beat)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        q_ptr_next = q_ptr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            level_reg         <= LV_FILE;
            stopped_reg       <= 1'b0;
            awaiting_reg      <= 1'b0;
            reading_tags_reg  <= 1'b1;
            tag_count_reg     <= '0;
            value_count_reg   <= '0;
            row_col_reg       <= '0;
            prev_valid_reg    <= 1'b0;
            first_valid_reg   <= 1'b0;
            error_halts_reg   <= 1'b1;
            warning_halts_reg <= 1'b0;
            div_cnt_reg       <= '0;
            q_cnt_reg         <= '0;
            q_ptr_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            level_reg        <= level_next;
            stopped_reg      <= stopped_next;
            awaiting_reg     <= awaiting_next;
            reading_tags_reg <= reading_tags_next;
            tag_count_reg    <= tag_count_next;
            value_count_reg  <= value_count_next;
            row_col_reg      <= row_col_next;
            prev_valid_reg   <= prev_valid_next;
            first_valid_reg  <= first_valid_next;
            div_cnt_reg      <= div_cnt_next;
            q_cnt_reg        <= q_cnt_next;
            q_ptr_reg        <= q_ptr_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_ERROR_HALTS:   error_halts_reg   <= cfg_data;
                    REG_WARNING_HALTS: warning_halts_reg <= cfg_data;
                    default:           error_halts_reg   <= error_halts_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_accept)
        begin
            tok_kind_reg  <= tokens.token_kind;
            tok_line_reg  <= tokens.line_number;
            tok_vk_reg    <= tokens.value_kind;
            tok_kw_reg    <= tokens.keyword_seen;
            tok_level_reg <= level_reg;
        end
        prev_line_reg  <= prev_line_next;
        first_line_reg <= first_line_next;
        count_line_reg <= count_line_next;
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        q_code_reg     <= q_code_next;
    end

endmodule

// File: tb/sv/star_token_grammar_checker_test.sv
// Self-checking testbench of the STAR token grammar checker: random and directed
// token streams, grammar events predicted in the bench and checked beat by beat.
// Depends on stgc_pkg, stgc_token_if, stgc_event_if and star_token_grammar_checker.
module star_token_grammar_checker_test;
    import stgc_pkg::*;

    localparam int COUNT_BITS = 16;
    localparam int LINE_BITS = 24;
    localparam int DRAIN_CYCLES = COUNT_BITS + 16;
    localparam logic [3:0] TK_SPARE_LOW = 4'd10;
    localparam logic [3:0] TK_SPARE_HIGH = 4'd15;

    typedef struct packed {
        logic [3:0]           kind;
        logic [LINE_BITS-1:0] line;
        logic [2:0]           quoting;
        logic                 keyword;
    } token_t;

    typedef struct packed {
        event_t               code;
        logic [LINE_BITS-1:0] line;
        logic [2:0]           quoting;
        level_t               nest;
        logic                 last;
        logic                 halt;
    } grammar_event_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_index;
    logic cfg_data;

    stgc_token_if #(.LINE_BITS(LINE_BITS)) token_ch ();
    stgc_event_if #(.LINE_BITS(LINE_BITS)) event_ch ();

    star_token_grammar_checker #(
        .COUNT_BITS(COUNT_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .tokens      (token_ch),
        .events      (event_ch),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // grammar state mirrored by the bench
    bit                    halts_on_error;
    bit                    halts_on_warning;
    level_t                nest;
    bit                    parse_stopped;
    bit                    value_pending;
    bit                    collecting_tags;
    logic [COUNT_BITS-1:0] tags_seen;
    logic [COUNT_BITS-1:0] values_seen;
    logic [COUNT_BITS-1:0] column;
    bit                    last_row_valid;
    logic [LINE_BITS-1:0]  last_row_line;
    bit                    first_row_valid;
    logic [LINE_BITS-1:0]  first_row_line;

    token_t               token_backlog[$];
    grammar_event_t       expected_events[$];
    grammar_event_t       token_events[$];
    token_t               on_wire;
    int                   failures;
    int                   idle_pct;
    int                   queued_tokens;
    logic [LINE_BITS-1:0] src_line;
    bit                   tidy;

    always #5 clk = ~clk;

    function automatic void note_event(event_t code, logic [LINE_BITS-1:0] ln, logic [2:0] q);
        grammar_event_t ev;
        ev.code = code;
        ev.line = ln;
        ev.quoting = q;
        ev.nest = nest;
        ev.last = 1'b0;
        ev.halt = 1'b0;
        token_events.push_back(ev);
    endfunction

    function automatic bit raise_error(event_t code, logic [LINE_BITS-1:0] ln, bit is_fatal);
        note_event(code, ln, 3'd0);
        if (is_fatal || halts_on_error)
            parse_stopped = 1'b1;
        return parse_stopped;
    endfunction

    function automatic logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void open_loop();
        collecting_tags = 1'b1;
        tags_seen = '0;
        values_seen = '0;
        column = '0;
        last_row_valid = 1'b0;
        last_row_line = '0;
        first_row_valid = 1'b0;
        first_row_line = '0;
    endfunction

    function automatic void emit_value(logic [LINE_BITS-1:0] ln, logic [2:0] q, logic kw);
        if (kw)
        begin
            note_event(EV_KEYWORDWARN, ln, 3'd0);
            if (halts_on_warning)
            begin
                parse_stopped = 1'b1;
                return;
            end
        end
        note_event(EV_VALUE, ln, q);
    endfunction

    function automatic void predict_events(token_t t);
        bit                   cut;
        bit                   warn_stop;
        logic [LINE_BITS-1:0] ln;
        grammar_event_t       tail;
        cut = 1'b0;
        warn_stop = 1'b0;
        ln = t.line;
        if (parse_stopped)
            return;
        token_events.delete();
        if (t.kind == TK_END)
        begin
            if (nest == LV_FILE || nest == LV_DATA)
            begin
                note_event(EV_ENDDATA, ln, 3'd0);
                parse_stopped = 1'b1;
            end
            else
                void'(raise_error(nest == LV_SAVE ? EV_NOSAVECLOSE : EV_NOSTOPCLOSE, ln, 1'b1));
        end
        else if (t.kind == TK_LEXERROR)
            void'(raise_error(EV_FATAL, ln, 1'b1));
        else if (t.kind == TK_COMMENT)
            note_event(EV_COMMENT, ln, 3'd0);
        else
        begin
            case (nest)
                LV_FILE:
                    if (t.kind == TK_DATASTART)
                    begin
                        note_event(EV_STARTDATA, ln, 3'd0);
                        nest = LV_DATA;
                    end
                    else
                        void'(raise_error(EV_INVALID, ln, 1'b0));
                LV_DATA:
                    if (t.kind == TK_SAVESTART)
                    begin
                        note_event(EV_STARTSAVE, ln, 3'd0);
                        nest = LV_SAVE;
                        value_pending = 1'b0;
                    end
                    else
                        void'(raise_error(EV_INVALID, ln, 1'b0));
                LV_SAVE:
                    case (t.kind)
                        TK_SAVEEND:
                        begin
                            if (value_pending)
                                cut = raise_error(EV_VALUEEXPECTED, ln, 1'b0);
                            if (!cut)
                            begin
                                note_event(EV_ENDSAVE, ln, 3'd0);
                                nest = LV_DATA;
                            end
                        end
                        TK_LOOPSTART:
                        begin
                            if (value_pending)
                                cut = raise_error(EV_VALUEEXPECTED, ln, 1'b0);
                            if (!cut)
                            begin
                                note_event(EV_STARTLOOP, ln, 3'd0);
                                nest = LV_LOOP;
                                open_loop();
                            end
                        end
                        TK_TAG:
                        begin
                            if (value_pending)
                                cut = raise_error(EV_VALUEEXPECTED, ln, 1'b0);
                            if (!cut)
                            begin
                                note_event(EV_TAG, ln, 3'd0);
                                value_pending = 1'b1;
                            end
                        end
                        TK_VALUE:
                        begin
                            if (!value_pending)
                                cut = raise_error(EV_VALUENOTEXP, ln, 1'b0);
                            if (!cut)
                            begin
                                value_pending = 1'b0;
                                emit_value(ln, t.quoting, t.keyword);
                            end
                        end
                        default:
                            void'(raise_error(EV_INVALID, ln, 1'b0));
                    endcase
                default:
                    case (t.kind)
                        TK_STOP:
                        begin
                            if (tags_seen == 0)
                                cut = raise_error(EV_NOTAGS, ln, 1'b0);
                            if (!cut && values_seen == 0)
                                cut = raise_error(EV_NOVALUES, ln, 1'b0);
                            if (!cut)
                            begin
                                if (tags_seen != 0 && (values_seen % tags_seen) != 0)
                                begin
                                    note_event(EV_COUNTWARN,
                                               first_row_valid ? first_row_line : ln, 3'd0);
                                    warn_stop = halts_on_warning;
                                end
                                note_event(EV_ENDLOOP, ln, 3'd0);
                                if (warn_stop)
                                    parse_stopped = 1'b1;
                                else
                                    nest = LV_SAVE;
                            end
                        end
                        TK_TAG:
                        begin
                            if (!collecting_tags)
                                cut = raise_error(EV_VALUEEXPECTED, ln, 1'b0);
                            if (!cut)
                            begin
                                note_event(EV_TAG, ln, 3'd0);
                                tags_seen = bump(tags_seen);
                            end
                        end
                        TK_VALUE:
                        begin
                            if (tags_seen == 0)
                                cut = raise_error(EV_NOTAGS, ln, 1'b0);
                            if (!cut)
                            begin
                                collecting_tags = 1'b0;
                                values_seen = bump(values_seen);
                                column = bump(column);
                                if (column == tags_seen)
                                begin
                                    if (!last_row_valid || last_row_line < ln)
                                    begin
                                        if (!first_row_valid)
                                        begin
                                            first_row_valid = 1'b1;
                                            first_row_line = ln;
                                        end
                                        last_row_valid = 1'b1;
                                        last_row_line = ln;
                                    end
                                    column = '0;
                                end
                                emit_value(ln, t.quoting, t.keyword);
                            end
                        end
                        default:
                            void'(raise_error(EV_INVALID, ln, 1'b0));
                    endcase
            endcase
        end
        if (token_events.size() != 0)
        begin
            tail = token_events.pop_back();
            tail.last = 1'b1;
            tail.halt = parse_stopped;
            token_events.push_back(tail);
        end
        foreach (token_events[i])
            expected_events.push_back(token_events[i]);
    endfunction

    function automatic string describe(grammar_event_t e);
        return $sformatf("code %0d line %0d quoting %0d level %0d last %0b halted %0b",
                         e.code, e.line, e.quoting, e.nest, e.last, e.halt);
    endfunction

    function automatic logic [2:0] pick_quoting();
        return ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    endfunction

    // token driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_ch.valid <= 1'b0;
            token_ch.token_kind <= '0;
            token_ch.line_number <= '0;
            token_ch.value_kind <= '0;
            token_ch.keyword_seen <= 1'b0;
        end
        else
        begin
            if (token_ch.valid && token_ch.ready)
                predict_events(on_wire);
            if (!token_ch.valid || token_ch.ready)
            begin
                if (token_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    on_wire = token_backlog.pop_front();
                    token_ch.valid <= 1'b1;
                    token_ch.token_kind <= on_wire.kind;
                    token_ch.line_number <= on_wire.line;
                    token_ch.value_kind <= on_wire.quoting;
                    token_ch.keyword_seen <= on_wire.keyword;
                end
                else
                    token_ch.valid <= 1'b0;
            end
        end
    end

    // event monitor
    always @(posedge clk or negedge rst_n)
    begin : watch
        grammar_event_t got;
        grammar_event_t want;
        if (!rst_n)
            event_ch.ready <= 1'b0;
        else
        begin
            if (event_ch.valid && event_ch.ready)
            begin
                got.code = event_t'(event_ch.event_code);
                got.line = event_ch.event_line;
                got.quoting = event_ch.event_value_kind;
                got.nest = level_t'(event_ch.nesting_level);
                got.last = event_ch.last_of_run;
                got.halt = event_ch.halted;
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected beat: expected none, actual %s",
                             $time, describe(got));
                    failures++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch: expected %s, actual %s",
                                 $time, describe(want), describe(got));
                        failures++;
                    end
                end
            end
            event_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    task automatic add_token(logic [3:0] k, logic [LINE_BITS-1:0] ln, logic [2:0] q, logic kw);
        token_t t;
        t.kind = k;
        t.line = ln;
        t.quoting = q;
        t.keyword = kw;
        token_backlog.push_back(t);
        queued_tokens++;
    endtask

    task automatic add_lexed(logic [3:0] k);
        int roll;
        roll = $urandom_range(0, 99);
        src_line = src_line + LINE_BITS'($urandom_range(0, 2));
        if (!tidy && $urandom_range(0, 39) == 0)
            src_line = LINE_BITS'($urandom);
        if (!tidy && roll < 3)
            return;
        if (!tidy && roll < 7)
            add_token(4'($urandom_range(TK_COMMENT, TK_SPARE_HIGH)), src_line,
                      pick_quoting(), 1'($urandom_range(0, 1)));
        if (roll >= 92)
            add_token(TK_COMMENT, src_line, pick_quoting(), 1'b0);
        add_token(k, src_line, pick_quoting(), tidy ? 1'b0 : ($urandom_range(0, 7) == 0));
    endtask

    task automatic add_loop();
        int n_tags;
        int rows;
        int spare;
        n_tags = tidy ? $urandom_range(1, 4) : $urandom_range(0, 4);
        rows = tidy ? $urandom_range(1, 3) : $urandom_range(0, 3);
        spare = (!tidy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        add_lexed(TK_LOOPSTART);
        repeat (n_tags)
            add_lexed(TK_TAG);
        repeat (n_tags * rows + spare)
            add_lexed(TK_VALUE);
        add_lexed(TK_STOP);
    endtask

    task automatic add_saveframe();
        add_lexed(TK_SAVESTART);
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 2) == 0)
                add_loop();
            else
            begin
                add_lexed(TK_TAG);
                add_lexed(TK_VALUE);
            end
        end
        add_lexed(TK_SAVEEND);
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        do
            @(negedge clk);
        while (token_backlog.size() != 0 || token_ch.valid);
        while (expected_events.size() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_ERROR_HALTS)
            halts_on_error = val;
        else
            halts_on_warning = val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // close any open loop and saveframe, back to data-block level
    task automatic realign();
        if (nest == LV_LOOP)
            add_token(TK_STOP, src_line, 3'd0, 1'b0);
        if (nest == LV_LOOP || nest == LV_SAVE)
        begin
            if (value_pending)
                add_token(TK_VALUE, src_line, 3'd0, 1'b0);
            add_token(TK_SAVEEND, src_line, 3'd0, 1'b0);
        end
        settle();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 1'b0;
        token_ch.valid = 1'b0;
        token_ch.token_kind = '0;
        token_ch.line_number = '0;
        token_ch.value_kind = '0;
        token_ch.keyword_seen = 1'b0;
        event_ch.ready = 1'b0;
        failures = 0;
        idle_pct = 29;
        queued_tokens = 0;
        src_line = '0;
        tidy = 1'b0;
        halts_on_error = 1'b1;
        halts_on_warning = 1'b0;
        nest = LV_FILE;
        parse_stopped = 1'b0;
        value_pending = 1'b0;
        open_loop();
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        write_reg(REG_ERROR_HALTS, 1'b0);
        write_reg(REG_WARNING_HALTS, 1'b0);

        add_token(TK_COMMENT, 24'd0, 3'd0, 1'b0);
        add_token(TK_SPARE_HIGH, 24'hFFFFFF, 3'd7, 1'b1);
        add_token(TK_VALUE, 24'd0, 3'd2, 1'b0);
        add_token(TK_DATASTART, 24'd1, 3'd0, 1'b0);
        add_token(TK_TAG, 24'd1, 3'd0, 1'b0);
        add_token(TK_SAVESTART, 24'd2, 3'd0, 1'b0);
        add_token(TK_VALUE, 24'd3, 3'd7, 1'b1);
        add_token(TK_TAG, 24'd4, 3'd0, 1'b0);
        add_token(TK_LOOPSTART, 24'd5, 3'd0, 1'b0);
        add_token(TK_VALUE, 24'd6, 3'd1, 1'b0);
        add_token(TK_STOP, 24'd7, 3'd0, 1'b0);
        add_token(TK_SAVEEND, 24'd8, 3'd0, 1'b0);
        add_token(TK_SAVESTART, 24'd9, 3'd0, 1'b0);
        add_token(TK_TAG, 24'd10, 3'd0, 1'b0);
        add_token(TK_VALUE, 24'd11, 3'd0, 1'b0);
        add_token(TK_LOOPSTART, 24'd12, 3'd0, 1'b0);
        add_token(TK_TAG, 24'd13, 3'd0, 1'b0);
        add_token(TK_TAG, 24'd13, 3'd0, 1'b0);
        add_token(TK_TAG, 24'd14, 3'd0, 1'b0);
        add_token(TK_VALUE, 24'd100, 3'd1, 1'b0);
        add_token(TK_VALUE, 24'd100, 3'd3, 1'b0);
        add_token(TK_VALUE, 24'hFFFFFF, 3'd4, 1'b1);
        add_token(TK_TAG, 24'd101, 3'd0, 1'b0);
        add_token(TK_SPARE_LOW, 24'd102, 3'd5, 1'b1);
        add_token(TK_STOP, 24'd103, 3'd0, 1'b0);
        add_token(TK_SAVEEND, 24'd104, 3'd0, 1'b0);
        src_line = 24'd110;
        settle();

        queued_tokens = 0;
        while (queued_tokens < 330)
            add_saveframe();
        // hold both sides busy through the middle of the stream
        while (token_backlog.size() > 230)
            @(negedge clk);
        idle_pct = 0;
        while (token_backlog.size() > 100)
            @(negedge clk);
        idle_pct = 29;
        settle();
        realign();

        write_reg(REG_ERROR_HALTS, 1'b1);
        tidy = 1'b1;
        queued_tokens = 0;
        while (queued_tokens < 40)
            add_saveframe();
        settle();

        write_reg(REG_ERROR_HALTS, 1'b0);
        write_reg(REG_WARNING_HALTS, 1'b1);
        queued_tokens = 0;
        while (queued_tokens < 40)
            add_saveframe();
        settle();

        write_reg(REG_ERROR_HALTS, 1'($urandom_range(0, 1)));
        write_reg(REG_WARNING_HALTS, 1'($urandom_range(0, 1)));
        tidy = 1'b0;
        queued_tokens = 0;
        while (queued_tokens < 60)
            add_saveframe();
        add_token($urandom_range(0, 1) ? TK_END : TK_LEXERROR, src_line, pick_quoting(), 1'b0);
        repeat (5)
            add_token(4'($urandom_range(0, 15)), LINE_BITS'($urandom), pick_quoting(),
                      1'($urandom_range(0, 1)));
        settle();

        if (expected_events.size() != 0)
        begin
            $display("%0t: %0d events never arrived, first expected %s, actual none",
                     $time, expected_events.size(), describe(expected_events[0]));
            failures++;
        end
        if (failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
